[sv/assert_macros.svh]
// assertion macros used by the checker file tsi_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge, off while reset is high
`define TSI_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequence checked in the cycle after the antecedent
`define TSI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/tsi_pkg.sv]
// types and constants of the three-way sorted intersection block
// no dependencies
package tsi_pkg;

   localparam int DEPTH     = 64;
   localparam int NUM_LISTS = 3;
   localparam int DATA_W    = 32;
   localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W     = $clog2(DEPTH + 1);

   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic [CNT_W-1:0]         count_type;
   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [1:0]               list_idx_type;

   localparam count_type CNT_MAX = CNT_W'(DEPTH);

   typedef enum logic [1:0] {
      OP_LOAD_FIRST  = 2'd0,
      OP_LOAD_SECOND = 2'd1,
      OP_LOAD_THIRD  = 2'd2,
      OP_RUN         = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [NUM_LISTS-1:0]     we;
      addr_type                 waddr;
      data_type                 wdata;
      addr_type [NUM_LISTS-1:0] raddr;
   } mem_ctl_type;

endpackage

[sv/tsi_ram.sv]
// generic single-write, single-read synchronous ram, registered read data
// no dependencies
module tsi_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[sv/tsi_ctrl.sv]
// list counts, walk pointers, sequencer and result register
// depends on tsi_pkg
module tsi_ctrl import tsi_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_operation,
   input  data_type                 req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output data_type                 rsp_common_value,
   output logic                     rsp_found,
   output logic                     rsp_last,
   output mem_ctl_type              mem_ctl,
   input  data_type [NUM_LISTS-1:0] rd_data
);

   state_type state_ff, state_in;
   count_type cnt_ff [NUM_LISTS];
   count_type cnt_in [NUM_LISTS];
   count_type ptr_ff [NUM_LISTS];
   count_type ptr_in [NUM_LISTS];
   logic      pend_valid_ff, pend_valid_in;
   data_type  pend_value_ff, pend_value_in;
   logic      rsp_valid_ff, rsp_valid_in;
   data_type  rsp_value_ff, rsp_value_in;
   logic      rsp_found_ff, rsp_found_in;
   logic      rsp_last_ff, rsp_last_in;

   op_type       op;
   logic         load_en;
   list_idx_type load_idx;
   logic         slot_free;
   logic         walk_done;
   logic         heads_equal;
   logic         emit_new;
   data_type     d0, d1, d2;

   assign op        = op_type'(req_operation);
   assign req_ready = (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign d0        = $signed(rd_data[0]);
   assign d1        = $signed(rd_data[1]);
   assign d2        = $signed(rd_data[2]);
   assign walk_done = (ptr_ff[0] >= cnt_ff[0]) || (ptr_ff[1] >= cnt_ff[1])
                   || (ptr_ff[2] >= cnt_ff[2]);
   assign heads_equal = (d0 == d1) && (d1 == d2);
   assign emit_new    = !pend_valid_ff || (d0 != pend_value_ff);

   always_comb begin
      load_en  = 1'b0;
      load_idx = 2'd0;
      case (op)
         OP_LOAD_FIRST: begin
            load_en  = 1'b1;
            load_idx = 2'd0;
         end
         OP_LOAD_SECOND: begin
            load_en  = 1'b1;
            load_idx = 2'd1;
         end
         OP_LOAD_THIRD: begin
            load_en  = 1'b1;
            load_idx = 2'd2;
         end
         default: begin
            load_en  = 1'b0;
            load_idx = 2'd0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_value_in = pend_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_last_in   = rsp_last_ff;
      mem_ctl.we    = '0;
      mem_ctl.waddr = '0;
      mem_ctl.wdata = req_value;

      case (state_ff)
         ST_IDLE: begin
            for (int l = 0; l < NUM_LISTS; l++) begin
               ptr_in[l] = '0;
            end
            if (req_valid) begin
               if (load_en) begin
                  if (cnt_ff[load_idx] < CNT_MAX) begin
                     mem_ctl.we[load_idx] = 1'b1;
                     mem_ctl.waddr        = cnt_ff[load_idx][ADDR_W-1:0];
                     cnt_in[load_idx]     = cnt_ff[load_idx] + 1'b1;
                  end
               end else begin
                  pend_valid_in = 1'b0;
                  state_in      = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (walk_done) begin
               state_in = ST_FINISH;
            end else if (heads_equal) begin
               if (!(emit_new && pend_valid_ff && !slot_free)) begin
                  if (emit_new && pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = pend_value_ff;
                     rsp_found_in = 1'b1;
                     rsp_last_in  = 1'b0;
                  end
                  if (emit_new) begin
                     pend_valid_in = 1'b1;
                     pend_value_in = d0;
                  end
                  for (int l = 0; l < NUM_LISTS; l++) begin
                     ptr_in[l] = ptr_ff[l] + 1'b1;
                  end
               end
            end else if (d0 < d1) begin
               ptr_in[0] = ptr_ff[0] + 1'b1;
            end else if (d1 < d2) begin
               ptr_in[1] = ptr_ff[1] + 1'b1;
            end else begin
               ptr_in[2] = ptr_ff[2] + 1'b1;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = pend_valid_ff ? pend_value_ff : '0;
               rsp_found_in  = pend_valid_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               for (int l = 0; l < NUM_LISTS; l++) begin
                  cnt_in[l] = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      for (int l = 0; l < NUM_LISTS; l++) begin
         mem_ctl.raddr[l] = ptr_in[l][ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int l = 0; l < NUM_LISTS; l++) begin
            cnt_ff[l] <= '0;
            ptr_ff[l] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         cnt_ff        <= cnt_in;
         ptr_ff        <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_value_ff <= pend_value_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_common_value = rsp_value_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

[sv/three_way_sorted_intersection_top.sv]
// channel   ports                                         direction
// req       req_valid req_ready req_operation req_value   in
// rsp       rsp_valid rsp_ready rsp_common_value          out
//           rsp_found rsp_last
// a load gives no item; a run walks the three list rams one pointer step at a
// time (at most the sum of the counts), and req_ready stays low until its
// last item is registered
// a new common value or the last item waits while the result register holds
// an untaken item
// reset clears counts and control only; list rams hold garbage until loaded
// top level: three list rams and the controller, depends on tsi_pkg
module three_way_sorted_intersection_top import tsi_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_operation,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_common_value,
   output logic                     rsp_found,
   output logic                     rsp_last
);

   mem_ctl_type              mem_ctl;
   data_type [NUM_LISTS-1:0] rd_data;

   for (genvar l = 0; l < NUM_LISTS; l++) begin : g_list
      tsi_ram #(
         .WIDTH  (DATA_W),
         .DEPTH  (DEPTH),
         .ADDR_W (ADDR_W)
      ) u_ram (
         .clock (clock),
         .we    (mem_ctl.we[l]),
         .waddr (mem_ctl.waddr),
         .wdata (mem_ctl.wdata),
         .raddr (mem_ctl.raddr[l]),
         .rdata (rd_data[l])
      );
   end

   tsi_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_common_value (rsp_common_value),
      .rsp_found        (rsp_found),
      .rsp_last         (rsp_last),
      .mem_ctl          (mem_ctl),
      .rd_data          (rd_data)
   );

endmodule

[sv/tsi_checker.sv]
// port-level checks of the intersection block, bound to the top level
// depends on tsi_pkg and assert_macros.svh
`include "assert_macros.svh"

module tsi_checker import tsi_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic [1:0]               req_operation,
   input logic signed [DATA_W-1:0] req_value,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [DATA_W-1:0] rsp_common_value,
   input logic                     rsp_found,
   input logic                     rsp_last
);

   `TSI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_common_value) && $stable(rsp_found) && $stable(rsp_last), "rsp item changed while stalled")
   `TSI_ASSERT_IMPL(a_miss_is_last, clock, reset, rsp_valid && !rsp_found, rsp_last, "empty result not marked last")
   `TSI_ASSERT_IMPL(a_miss_is_zero, clock, reset, rsp_valid && !rsp_found, rsp_common_value == '0, "empty result carries a value")
   `TSI_ASSERT_NEXT(a_run_busy, clock, reset, req_valid && req_ready && (req_operation == OP_RUN), !req_ready, "req taken right after a run")

endmodule

bind three_way_sorted_intersection_top tsi_checker u_tsi_checker (.*);

[tb/tb_top.sv]
// self-checking testbench for three_way_sorted_intersection_top: a directed table, then
// random list loads and runs, with results predicted by a behavioral list walk
// depends on tsi_pkg and three_way_sorted_intersection_top
module tb_top import tsi_pkg::*;;

   typedef struct packed {
      data_type common_value;
      logic     found;
      logic     last;
   } common_result_type;

   typedef struct packed {
      op_type            op;
      data_type          value;
      logic              typed;
      common_result_type want;
   } stim_row_type;

   localparam common_result_type NO_RESULT = '0;
   localparam int                N_DIRECTED = 22;
   localparam int                N_RANDOM = 350;

   localparam stim_row_type DIRECTED [N_DIRECTED] = '{
      '{OP_RUN,         32'sd0,           1'b1, '{32'sd0, 1'b0, 1'b1}},
      '{OP_LOAD_FIRST,  32'sh80000000,    1'b0, NO_RESULT},
      '{OP_LOAD_SECOND, 32'sh80000000,    1'b0, NO_RESULT},
      '{OP_LOAD_THIRD,  32'sh80000000,    1'b0, NO_RESULT},
      '{OP_RUN,         32'sd0,           1'b1, '{32'sh80000000, 1'b1, 1'b1}},
      '{OP_LOAD_FIRST,  32'sd5,           1'b0, NO_RESULT},
      '{OP_LOAD_SECOND, 32'sd5,           1'b0, NO_RESULT},
      '{OP_RUN,         32'sh7fffffff,    1'b1, '{32'sd0, 1'b0, 1'b1}},
      '{OP_LOAD_FIRST,  32'sd7,           1'b0, NO_RESULT},
      '{OP_LOAD_FIRST,  32'sd7,           1'b0, NO_RESULT},
      '{OP_LOAD_SECOND, 32'sd7,           1'b0, NO_RESULT},
      '{OP_LOAD_SECOND, 32'sd7,           1'b0, NO_RESULT},
      '{OP_LOAD_THIRD,  32'sd7,           1'b0, NO_RESULT},
      '{OP_LOAD_THIRD,  32'sd7,           1'b0, NO_RESULT},
      '{OP_RUN,         32'sd0,           1'b0, NO_RESULT},
      '{OP_LOAD_FIRST,  32'sh7fffffff,    1'b0, NO_RESULT},
      '{OP_LOAD_FIRST,  32'sh80000000,    1'b0, NO_RESULT},
      '{OP_LOAD_SECOND, 32'sh7fffffff,    1'b0, NO_RESULT},
      '{OP_LOAD_SECOND, 32'sh80000000,    1'b0, NO_RESULT},
      '{OP_LOAD_THIRD,  32'sh7fffffff,    1'b0, NO_RESULT},
      '{OP_LOAD_THIRD,  32'sh80000000,    1'b0, NO_RESULT},
      '{OP_RUN,         32'shffffffff,    1'b0, NO_RESULT}
   };

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   op_type   req_operation = OP_LOAD_FIRST;
   data_type req_value = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   data_type rsp_common_value;
   logic     rsp_found;
   logic     rsp_last;

   data_type          list_vals [NUM_LISTS][DEPTH];
   int                list_len [NUM_LISTS];
   common_result_type walk_results [$];
   common_result_type expected_commons [$];
   common_result_type oldest;
   int                error_count = 0;
   int                items_sent = 0;
   bit                steady = 1'b0;

   three_way_sorted_intersection_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_common_value (rsp_common_value),
      .rsp_found        (rsp_found),
      .rsp_last         (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // append to a list or walk all three, leaving the results in walk_results
   function automatic void step_lists(input op_type op, input data_type val);
      int                i;
      int                j;
      int                k;
      data_type          a;
      data_type          b;
      data_type          c;
      data_type          prev;
      bit                any;
      common_result_type r;
      walk_results.delete();
      if (op != OP_RUN) begin
         if (list_len[op] < DEPTH) begin
            list_vals[op][list_len[op]] = val;
            list_len[op]++;
         end
         return;
      end
      i = 0;
      j = 0;
      k = 0;
      any = 1'b0;
      prev = '0;
      while (i < list_len[0] && j < list_len[1] && k < list_len[2]) begin
         a = list_vals[0][i];
         b = list_vals[1][j];
         c = list_vals[2][k];
         if (a == b && b == c) begin
            if (!any || a != prev) begin
               r.common_value = a;
               r.found = 1'b1;
               r.last = 1'b0;
               walk_results = {walk_results, r};
               prev = a;
               any = 1'b1;
            end
            i++;
            j++;
            k++;
         end else if (a < b) begin
            i++;
         end else if (b < c) begin
            j++;
         end else begin
            k++;
         end
      end
      if (walk_results.size() == 0) begin
         r.common_value = '0;
         r.found = 1'b0;
         r.last = 1'b1;
         walk_results = {walk_results, r};
      end else begin
         walk_results[walk_results.size() - 1].last = 1'b1;
      end
      for (int n = 0; n < NUM_LISTS; n++) list_len[n] = 0;
   endfunction

   task automatic send_item(input op_type op, input data_type val, input bit typed,
                            input common_result_type want);
      if (!steady && $urandom_range(0, 99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while (!steady && $urandom_range(0, 99) < 29) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_value <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == OP_RUN || list_len[op] < DEPTH) items_sent++;
      step_lists(op, val);
      if (typed) begin
         expected_commons = {expected_commons, want};
      end else begin
         foreach (walk_results[n]) expected_commons = {expected_commons, walk_results[n]};
      end
   endtask

   // non-descending lists drawn from one pool, loads interleaved, then a run
   task automatic load_sorted_lists(input int pool_size, input bit fill_first);
      longint   cur;
      data_type pool [0:79];
      int       pool_n;
      data_type plan [NUM_LISTS][0:159];
      int       plan_len [NUM_LISTS];
      int       plan_pos [NUM_LISTS];
      int       pick;
      int       keep;
      pool_n = 0;
      cur = ($urandom_range(0, 9) == 0) ? -64'sd2147483648 : longint'(int'($urandom));
      while (pool_n < pool_size && cur <= 64'sd2147483647) begin
         pool[pool_n] = data_type'(cur);
         pool_n++;
         if ($urandom_range(0, 9) < 7) cur += $urandom_range(1, 4);
         else cur += $urandom_range(1, 1 << 28);
      end
      for (int l = 0; l < NUM_LISTS; l++) begin
         plan_len[l] = 0;
         plan_pos[l] = 0;
      end
      keep = fill_first ? 25 : 70;
      for (int p = 0; p < pool_n; p++) begin
         for (int l = 0; l < NUM_LISTS; l++) begin
            if ((fill_first && l == 0) || $urandom_range(0, 99) < keep) begin
               plan[l][plan_len[l]] = pool[p];
               plan_len[l]++;
               if (!fill_first && $urandom_range(0, 99) < 12) begin
                  plan[l][plan_len[l]] = pool[p];
                  plan_len[l]++;
               end
            end
         end
      end
      while (plan_pos[0] < plan_len[0] || plan_pos[1] < plan_len[1]
             || plan_pos[2] < plan_len[2]) begin
         pick = $urandom_range(0, NUM_LISTS - 1);
         if (plan_pos[pick] < plan_len[pick]) begin
            send_item(op_type'(pick), plan[pick][plan_pos[pick]], 1'b0, NO_RESULT);
            plan_pos[pick]++;
         end
      end
      send_item(OP_RUN, data_type'($urandom), 1'b0, NO_RESULT);
   endtask

   // unordered loads with runs at random points
   task automatic scramble_lists();
      int n;
      n = $urandom_range(1, 10);
      repeat (n) begin
         if ($urandom_range(0, 3) == 0)
            send_item(OP_RUN, data_type'($urandom), 1'b0, NO_RESULT);
         else
            send_item(op_type'($urandom_range(0, 2)), data_type'($urandom), 1'b0, NO_RESULT);
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 29);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_commons.size() == 0) begin
            $error("unexpected item: common_value %0d found %0b last %0b",
                   rsp_common_value, rsp_found, rsp_last);
            error_count++;
         end else begin
            oldest = expected_commons.pop_front();
            if (rsp_common_value !== oldest.common_value) begin
               $error("common_value: expected %0d, got %0d",
                      oldest.common_value, rsp_common_value);
               error_count++;
            end
            if (rsp_found !== oldest.found) begin
               $error("found: expected %0b, got %0b", oldest.found, rsp_found);
               error_count++;
            end
            if (rsp_last !== oldest.last) begin
               $error("last: expected %0b, got %0b", oldest.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   initial begin
      int seq;
      for (int l = 0; l < NUM_LISTS; l++) list_len[l] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int r = 0; r < N_DIRECTED; r++)
         send_item(DIRECTED[r].op, DIRECTED[r].value, DIRECTED[r].typed, DIRECTED[r].want);
      seq = 0;
      while (items_sent < N_DIRECTED + N_RANDOM) begin
         steady = (seq >= 12 && seq < 20);
         if (seq == 6) load_sorted_lists(70, 1'b1);
         else if ($urandom_range(0, 9) < 7) load_sorted_lists($urandom_range(1, 12), 1'b0);
         else scramble_lists();
         seq++;
      end
      steady = 1'b0;
      req_valid <= 1'b0;
      while (expected_commons.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
